FILE: design/packet_deframe_xor_descramble_defines.svh
// ----------------------------------------------------------------------------
// packet_deframe_xor_descramble assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAME_XOR_DESCRAMBLE_DEFINES_SVH
`define PACKET_DEFRAME_XOR_DESCRAMBLE_DEFINES_SVH

// same-cycle implication
`define PDX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PDX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/pdx_pkg.sv
// ----------------------------------------------------------------------------
// pdx_pkg
// constants, types and the mask function of the packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

package pdx_pkg;

  // default packet size that is kept and replayed
  localparam int PACKET_BYTES_DEF = 64;

  localparam int BYTE_W  = 8;
  localparam int INDEX_W = 6;
  localparam int REM_W   = 9;

  // framing bytes
  localparam logic [BYTE_W-1:0] SYNC_LEAD = 8'h55;
  localparam logic [BYTE_W-1:0] SYNC_NEXT = 8'hAA;

  // header word of a scrambled packet, bytes 0..3 little-endian
  localparam logic [31:0] HDR_WORD = 32'h3a10aa55;

  // byte positions used by the mask logic
  localparam int IDX_AGREE  = 51;
  localparam int IDX_MASK_A = 52;
  localparam int IDX_MASK_C = 60;

  // controller to datapath commands
  typedef struct packed {
    logic keep;        // store the input byte at the fill position
    logic restart;     // store the input byte as byte 0 of a new packet
    logic load_len;    // load remaining count from the length byte
    logic dec_rem;     // count down the remaining bytes
    logic start_dump;  // latch the mask and read byte 0
    logic advance;     // read the next stored byte
  } pdx_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_lead;     // input byte is the lead sync byte
    logic is_next;     // input byte is the second sync byte
    logic rem_done;    // this body byte ends the packet
    logic fill_done;   // this byte brings the packet to full size
    logic idx_last;    // replay is on the final byte
  } pdx_status_t;

  // mask from raw bytes 52 (a) and 60 (c)
  function automatic logic [BYTE_W-1:0] build_mask(input logic [BYTE_W-1:0] a,
                                                   input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] m;
    m[0] = a[0] ^ c[4];
    m[1] = a[1] ^ c[5];
    m[2] = a[2] ^ c[6];
    m[3] = a[3] ^ c[7] ^ a[0];
    m[4] = a[1];
    m[5] = a[2];
    m[6] = a[3];
    m[7] = a[0] ^ c[4];
    return m;
  endfunction

endpackage

`default_nettype wire

FILE: design/pdx_ifs.sv
// ----------------------------------------------------------------------------
// pdx stream interfaces
// valid/ready channels for raw input bytes and descrambled results
// ----------------------------------------------------------------------------
`default_nettype none

interface pdx_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdx_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface pdx_out_if;
  logic                         valid;
  logic                         ready;
  logic [pdx_pkg::BYTE_W-1:0]   plain_byte;
  logic [pdx_pkg::INDEX_W-1:0]  byte_index;
  logic                         last_byte;
  logic [pdx_pkg::BYTE_W-1:0]   mask_value;
  logic                         mask_agrees;

  modport source (output valid, output plain_byte, output byte_index,
                  output last_byte, output mask_value, output mask_agrees,
                  input ready);
  modport sink   (input valid, input plain_byte, input byte_index,
                  input last_byte, input mask_value, input mask_agrees,
                  output ready);
endinterface

`default_nettype wire

FILE: design/pdx_ram.sv
// ----------------------------------------------------------------------------
// pdx_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pdx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, holds its data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/pdx_ctrl.sv
// ----------------------------------------------------------------------------
// pdx_ctrl
// framing and replay state machine of the packet deframer
// ----------------------------------------------------------------------------
`default_nettype none

module pdx_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire pdx_pkg::pdx_status_t status,
  output pdx_pkg::pdx_cmd_t         cmd
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SYNC = 6'b000010,
    ST_ID   = 6'b000100,
    ST_LEN  = 6'b001000,
    ST_BODY = 6'b010000,
    ST_DUMP = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer;

  assign in_ready  = (state_r != ST_DUMP);
  assign out_valid = (state_r == ST_DUMP);
  assign in_xfer   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer && status.is_lead) begin
          cmd.restart = 1'b1;
          state_nxt   = ST_SYNC;
        end
      end
      ST_SYNC: begin
        if (in_xfer) begin
          priority if (status.is_next) begin
            cmd.keep  = 1'b1;
            state_nxt = ST_ID;
          end else if (status.is_lead) begin
            cmd.restart = 1'b1;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_ID: begin
        if (in_xfer) begin
          cmd.keep  = 1'b1;
          state_nxt = ST_LEN;
        end
      end
      ST_LEN: begin
        if (in_xfer) begin
          cmd.keep     = 1'b1;
          cmd.load_len = 1'b1;
          state_nxt    = ST_BODY;
        end
      end
      ST_BODY: begin
        if (in_xfer) begin
          cmd.keep    = 1'b1;
          cmd.dec_rem = 1'b1;
          if (status.rem_done) begin
            if (status.fill_done) begin
              cmd.start_dump = 1'b1;
              state_nxt      = ST_DUMP;
            end else begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      ST_DUMP: begin
        if (out_ready) begin
          if (status.idx_last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/pdx_datapath.sv
// ----------------------------------------------------------------------------
// pdx_datapath
// packet store, byte counters, header capture and mask logic
// ----------------------------------------------------------------------------
`default_nettype none

module pdx_datapath #(
  parameter int PACKET_BYTES = pdx_pkg::PACKET_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [pdx_pkg::BYTE_W-1:0]    rx_byte,
  input  wire pdx_pkg::pdx_cmd_t             cmd,
  output pdx_pkg::pdx_status_t               status,
  output logic      [pdx_pkg::BYTE_W-1:0]    plain_byte,
  output logic      [pdx_pkg::INDEX_W-1:0]   byte_index,
  output logic                               last_byte,
  output logic      [pdx_pkg::BYTE_W-1:0]    mask_value,
  output logic                               mask_agrees
);

  localparam int AW = $clog2(PACKET_BYTES);
  localparam int FW = $clog2(PACKET_BYTES + 2);
  localparam int BW = pdx_pkg::BYTE_W;

  logic [pdx_pkg::REM_W-1:0] rem_r, rem_nxt;
  logic [FW-1:0]             fill_r, fill_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [FW-1:0]             wr_idx;
  logic                      store;
  logic                      wr_en;
  logic                      rd_en;
  logic [AW-1:0]             rd_addr;
  logic [BW-1:0]             rd_data;
  logic [BW-1:0]             hdr0_r, hdr1_r, hdr2_r, hdr3_r;
  logic [BW-1:0]             agree_r, byte_a_r, byte_c_r;
  logic [BW-1:0]             mask_r;
  logic                      agrees_r;
  logic [BW-1:0]             mask_calc;

  // store position: a restart goes to byte 0
  assign store  = cmd.keep || cmd.restart;
  assign wr_idx = cmd.restart ? '0 : fill_r;
  assign wr_en  = store && (wr_idx < FW'(PACKET_BYTES));

  // fill count, saturating one past the packet size
  always_comb begin
    fill_nxt = fill_r;
    if (cmd.restart) begin
      fill_nxt = FW'(1);
    end else if (cmd.keep && (fill_r <= FW'(PACKET_BYTES))) begin
      fill_nxt = fill_r + FW'(1);
    end
  end

  // remaining payload plus checksum bytes
  always_comb begin
    rem_nxt = rem_r;
    if (cmd.load_len) begin
      rem_nxt = {1'b0, rx_byte} + pdx_pkg::REM_W'(2);
    end else if (cmd.dec_rem && (rem_r != '0)) begin
      rem_nxt = rem_r - pdx_pkg::REM_W'(1);
    end
  end

  // replay index and read address
  always_comb begin
    idx_nxt = idx_r;
    rd_en   = cmd.start_dump || cmd.advance;
    rd_addr = cmd.start_dump ? '0 : idx_r + AW'(1);
    if (cmd.start_dump) begin
      idx_nxt = '0;
    end else if (cmd.advance) begin
      idx_nxt = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= '0;
      fill_r <= '0;
      idx_r  <= '0;
    end else begin
      rem_r  <= rem_nxt;
      fill_r <= fill_nxt;
      idx_r  <= idx_nxt;
    end
  end

  // capture of the bytes the mask logic needs
  always_ff @(posedge clk) begin
    if (store) begin
      if (wr_idx == FW'(0))                   hdr0_r   <= rx_byte;
      if (wr_idx == FW'(1))                   hdr1_r   <= rx_byte;
      if (wr_idx == FW'(2))                   hdr2_r   <= rx_byte;
      if (wr_idx == FW'(3))                   hdr3_r   <= rx_byte;
      if (wr_idx == FW'(pdx_pkg::IDX_AGREE))  agree_r  <= rx_byte;
      if (wr_idx == FW'(pdx_pkg::IDX_MASK_A)) byte_a_r <= rx_byte;
      if (wr_idx == FW'(pdx_pkg::IDX_MASK_C)) byte_c_r <= rx_byte;
    end
  end

  // mask, zero unless the header word matches
  assign mask_calc = ({hdr3_r, hdr2_r, hdr1_r, hdr0_r} == pdx_pkg::HDR_WORD)
                   ? pdx_pkg::build_mask(byte_a_r, byte_c_r) : '0;

  always_ff @(posedge clk) begin
    if (cmd.start_dump) begin
      mask_r   <= mask_calc;
      agrees_r <= (mask_calc == agree_r);
    end
  end

  pdx_ram #(
    .WIDTH (BW),
    .DEPTH (PACKET_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_idx[AW-1:0]),
    .wr_data (rx_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // status to the controller
  assign status.is_lead   = (rx_byte == pdx_pkg::SYNC_LEAD);
  assign status.is_next   = (rx_byte == pdx_pkg::SYNC_NEXT);
  assign status.rem_done  = (rem_r <= pdx_pkg::REM_W'(1));
  assign status.fill_done = (fill_r == FW'(PACKET_BYTES - 1));
  assign status.idx_last  = (idx_r == AW'(PACKET_BYTES - 1));

  // result payload
  assign plain_byte  = rd_data ^ mask_r;
  assign byte_index  = idx_r[pdx_pkg::INDEX_W-1:0];
  assign last_byte   = status.idx_last;
  assign mask_value  = mask_r;
  assign mask_agrees = agrees_r;

endmodule

`default_nettype wire

FILE: design/packet_deframe_xor_descramble.sv
// ----------------------------------------------------------------------------
// packet_deframe_xor_descramble
// deframes 55 AA id len body packets and replays full-size ones descrambled
// ----------------------------------------------------------------------------
// in_chan takes one raw stream byte per transfer, one per cycle while the
// block is receiving. A packet is lead byte, sync byte, id, length L and
// L+2 further bytes; only packets of exactly PACKET_BYTES bytes give results.
// The final byte of such a packet starts a replay: the first result is
// offered on out_chan in the cycle after that byte's transfer, and the
// packet's PACKET_BYTES results follow at one per cycle while the receiver
// is ready, paced by the single read port of the packet store. in_ready is
// low during the replay, so no input is taken while results are offered.
// Each result holds the byte XORed with the packet mask, its index modulo
// 64, a last flag, the mask and whether it matches raw byte 51.
// When the receiver stalls, the current result holds and the replay waits.
// Reset returns the framer to waiting for a lead byte and aborts any replay;
// the packet store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_deframe_xor_descramble_defines.svh"

module packet_deframe_xor_descramble #(
  parameter int PACKET_BYTES = pdx_pkg::PACKET_BYTES_DEF
) (
  input wire logic   clk,
  input wire logic   rst_n,
  pdx_in_if.sink     in_chan,
  pdx_out_if.source  out_chan
);

  pdx_pkg::pdx_cmd_t    cmd;
  pdx_pkg::pdx_status_t status;

  // framing and replay control
  pdx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // store, counters and mask
  pdx_datapath #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .rx_byte     (in_chan.rx_byte),
    .cmd         (cmd),
    .status      (status),
    .plain_byte  (out_chan.plain_byte),
    .byte_index  (out_chan.byte_index),
    .last_byte   (out_chan.last_byte),
    .mask_value  (out_chan.mask_value),
    .mask_agrees (out_chan.mask_agrees)
  );

  // checks
  `PDX_ASSERT_NOW(a_no_input_in_replay, out_chan.valid, !in_chan.ready, "input taken during replay")
  `PDX_ASSERT_NEXT(a_replay_continues, out_chan.valid && out_chan.ready && !out_chan.last_byte, out_chan.valid && (out_chan.byte_index == $past(out_chan.byte_index) + pdx_pkg::INDEX_W'(1)), "replay skipped or stopped")
  `PDX_ASSERT_NEXT(a_mask_steady, out_chan.valid && out_chan.ready && !out_chan.last_byte, out_chan.mask_value == $past(out_chan.mask_value), "mask changed within a packet")
  `PDX_ASSERT_NEXT(a_replay_ends, out_chan.valid && out_chan.ready && out_chan.last_byte, in_chan.ready && !out_chan.valid, "replay did not end after last byte")

endmodule

`default_nettype wire

FILE: verif/packet_deframe_xor_descramble_tb.sv
// ----------------------------------------------------------------------------
// packet_deframe_xor_descramble_tb
// drives raw stream bytes into the deframer and checks every replayed byte
// directed table: noise, broken sync, doubled lead, short and long frames,
// a scrambled packet with a typed-in mask, then random frames
// both channel sides idle at random, results compared field by field in order
// ----------------------------------------------------------------------------
module packet_deframe_xor_descramble_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PKT          = pdx_pkg::PACKET_BYTES_DEF;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_AT      = 10;    // result count that triggers the long stall
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_TAIL   = 16;
  localparam int RAND_BYTES   = 60;
  localparam int RAND_PACKETS = 1;

  typedef logic [pdx_pkg::BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    PH_WAIT_LEAD, PH_WAIT_SYNC, PH_TAKE_ID, PH_TAKE_LEN, PH_TAKE_BODY
  } frame_phase_t;

  typedef struct packed {
    byte_t                       plain;
    logic [pdx_pkg::INDEX_W-1:0] pos;
    logic                        last;
    byte_t                       mask;
    logic                        agrees;
  } plain_rec_t;

  typedef enum logic [1:0] {ROW_NOISE, ROW_BROKEN, ROW_FRAME} row_kind_t;
  // how a row is checked: model, typed-in mask, or typed-in "no results"
  typedef enum logic [1:0] {CHK_PREDICT, CHK_MASK, CHK_NONE} row_check_t;

  typedef struct packed {
    row_kind_t  kind;
    byte_t      b0;          // noise byte, byte after the lead, or frame id
    byte_t      len_b;
    byte_t      fill;
    logic       rand_body;
    logic       extra_lead;
    row_check_t check;
    byte_t      mask;
  } stim_row_t;

  localparam int PLAN_ROWS = 7;
  localparam stim_row_t PLAN [PLAN_ROWS] = '{
    // bytes outside a packet
    '{ROW_NOISE,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, CHK_PREDICT, 8'h00},
    '{ROW_NOISE,  8'hAA, 8'h00, 8'h00, 1'b0, 1'b0, CHK_PREDICT, 8'h00},
    // doubled lead, scrambled header, all-ones body
    '{ROW_FRAME,  8'h10, 8'h3A, 8'hFF, 1'b0, 1'b1, CHK_MASK,    8'h78},
    // one byte too long, so no results
    '{ROW_FRAME,  8'h10, 8'h3B, 8'h5A, 1'b0, 1'b0, CHK_NONE,    8'h00},
    // lead not followed by sync, then lead followed by a second lead
    '{ROW_BROKEN, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0, CHK_PREDICT, 8'h00},
    '{ROW_BROKEN, 8'h55, 8'h00, 8'h00, 1'b0, 1'b0, CHK_PREDICT, 8'h00},
    // shortest length byte
    '{ROW_FRAME,  8'h00, 8'h00, 8'h00, 1'b0, 1'b0, CHK_NONE,    8'h00}
  };

  logic clk;
  logic rst_n;

  pdx_in_if  in_chan();
  pdx_out_if out_chan();

  packet_deframe_xor_descramble #(
    .PACKET_BYTES(PKT)
  ) uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  // deframer model state
  frame_phase_t phase;
  logic [8:0]   bytes_left;
  int           fill_count;
  byte_t        packet_store [PKT];

  plain_rec_t expected_plain [$];

  int  errors;
  int  cycle_count;
  int  in_transfers;
  int  frame_bytes;
  int  full_packets;
  int  results_seen;
  int  agree_packets;
  int  rx_gap;
  bit  rx_burst;
  bit  tx_burst;
  bit  long_hold_due;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("packet_deframe_xor_descramble verification failed");
      $finish;
    end
  end

  // mask from raw bytes 52 (a) and 60 (c)
  function automatic byte_t scramble_mask(input byte_t a, input byte_t c);
    logic x0;
    x0 = a[0] ^ c[4];
    return {x0, a[3], a[2], a[1], a[3] ^ c[7] ^ a[0], a[2] ^ c[6], a[1] ^ c[5], x0};
  endfunction

  function automatic byte_t packet_mask();
    if ({packet_store[3], packet_store[2], packet_store[1], packet_store[0]}
        != pdx_pkg::HDR_WORD)
      return '0;
    return scramble_mask(packet_store[pdx_pkg::IDX_MASK_A],
                         packet_store[pdx_pkg::IDX_MASK_C]);
  endfunction

  task automatic store_byte(input byte_t b);
    if (fill_count < PKT) packet_store[fill_count] = b;
    if (fill_count <= PKT) fill_count++;
  endtask

  // advance the deframer model by one accepted byte; publish queues the results
  task automatic deframe_step(input byte_t b, input bit publish);
    bit         done;
    byte_t      m;
    plain_rec_t rec;
    done = 1'b0;
    case (phase)
      PH_WAIT_LEAD: begin
        if (b == pdx_pkg::SYNC_LEAD) begin
          fill_count = 0;
          store_byte(b);
          phase = PH_WAIT_SYNC;
        end
      end
      PH_WAIT_SYNC: begin
        if (b == pdx_pkg::SYNC_NEXT) begin
          store_byte(b);
          phase = PH_TAKE_ID;
        end else if (b == pdx_pkg::SYNC_LEAD) begin
          fill_count = 0;
          store_byte(b);
        end else begin
          phase = PH_WAIT_LEAD;
        end
      end
      PH_TAKE_ID: begin
        store_byte(b);
        phase = PH_TAKE_LEN;
      end
      PH_TAKE_LEN: begin
        store_byte(b);
        bytes_left = {1'b0, b} + 9'd2;
        phase = PH_TAKE_BODY;
      end
      default: begin
        store_byte(b);
        if (bytes_left != 0) bytes_left--;
        if (bytes_left == 0) begin
          phase = PH_WAIT_LEAD;
          done = (fill_count == PKT);
        end
      end
    endcase
    if (done) begin
      full_packets++;
      m = packet_mask();
      if (publish) begin
        for (int i = 0; i < PKT; i++) begin
          rec.plain  = packet_store[i] ^ m;
          rec.pos    = pdx_pkg::INDEX_W'(i);
          rec.last   = (i == PKT - 1);
          rec.mask   = m;
          rec.agrees = (m == packet_store[pdx_pkg::IDX_AGREE]);
          expected_plain = {expected_plain, rec};
        end
      end
    end
  endtask

  // one input transfer, after a random idle gap
  task automatic send_byte(input byte_t b, input bit publish);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid   <= 1'b1;
    in_chan.rx_byte <= b;
    do @(posedge clk); while (!in_chan.ready);
    in_transfers++;
    deframe_step(b, publish);
  endtask

  task automatic send_frame(input byte_t id_b, input byte_t len_b, input byte_t body [$],
                            input bit publish);
    send_byte(pdx_pkg::SYNC_LEAD, publish);
    send_byte(pdx_pkg::SYNC_NEXT, publish);
    send_byte(id_b, publish);
    send_byte(len_b, publish);
    foreach (body[k]) send_byte(body[k], publish);
    frame_bytes += 4 + body.size();
  endtask

  task automatic fill_body(output byte_t body [$], input byte_t len_b, input byte_t fill,
                           input bit rand_body);
    body = {};
    repeat (int'(len_b) + 2)
      body = {body, rand_body ? byte_t'($urandom_range(0, 255)) : fill};
  endtask

  // sender holds off until every expected result has come
  task automatic pause_until_drained();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (expected_plain.size() == 0);
    repeat (4) @(posedge clk);
  endtask

  // result receiver: ready with random stalls and one long hold-off
  initial begin : result_drain
    out_chan.ready = 1'b0;
    rx_gap         = 0;
    rx_burst       = 1'b0;
    long_hold_due  = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    plain_rec_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_plain.size() == 0) begin
        $error("unexpected result: plain_byte %h byte_index %0d",
               out_chan.plain_byte, out_chan.byte_index);
        errors++;
      end else begin
        want = expected_plain.pop_front();
        if (out_chan.plain_byte !== want.plain) begin
          $error("plain_byte: expected %h, got %h", want.plain, out_chan.plain_byte);
          errors++;
        end
        if (out_chan.byte_index !== want.pos) begin
          $error("byte_index: expected %0d, got %0d", want.pos, out_chan.byte_index);
          errors++;
        end
        if (out_chan.last_byte !== want.last) begin
          $error("last_byte: expected %b, got %b", want.last, out_chan.last_byte);
          errors++;
        end
        if (out_chan.mask_value !== want.mask) begin
          $error("mask_value: expected %h, got %h", want.mask, out_chan.mask_value);
          errors++;
        end
        if (out_chan.mask_agrees !== want.agrees) begin
          $error("mask_agrees: expected %b, got %b", want.agrees, out_chan.mask_agrees);
          errors++;
        end
        if (want.last && want.agrees) agree_packets++;
      end
      results_seen++;
      if (results_seen == HOLD_AT) long_hold_due = 1'b1;
      if (results_seen % 40 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      rx_gap = rx_burst ? 0 : $urandom_range(0, 3);
    end
  end

  // stimulus
  initial begin : stimulus
    stim_row_t  row;
    byte_t      body [$];
    byte_t      id_b;
    byte_t      len_b;
    byte_t      m;
    plain_rec_t rec;
    int         pick;
    int         base_bytes;
    int         base_packets;

    errors        = 0;
    in_transfers  = 0;
    frame_bytes   = 0;
    full_packets  = 0;
    results_seen  = 0;
    agree_packets = 0;
    tx_burst      = 1'b0;
    phase         = PH_WAIT_LEAD;
    bytes_left    = '0;
    fill_count    = 0;
    foreach (packet_store[i]) packet_store[i] = '0;

    in_chan.valid   = 1'b0;
    in_chan.rx_byte = '0;
    rst_n           = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = PLAN[r];
      tx_burst = ($urandom_range(0, 1) == 0);
      case (row.kind)
        ROW_NOISE: send_byte(row.b0, 1'b1);
        ROW_BROKEN: begin
          send_byte(pdx_pkg::SYNC_LEAD, 1'b1);
          send_byte(row.b0, 1'b1);
        end
        default: begin
          fill_body(body, row.len_b, row.fill, row.rand_body);
          if (row.extra_lead) send_byte(pdx_pkg::SYNC_LEAD, row.check == CHK_PREDICT);
          send_frame(row.b0, row.len_b, body, row.check == CHK_PREDICT);
          // typed-in results of a constant-fill packet
          if (row.check == CHK_MASK) begin
            for (int i = 0; i < PKT; i++) begin
              case (i)
                0:       rec.plain = pdx_pkg::SYNC_LEAD;
                1:       rec.plain = pdx_pkg::SYNC_NEXT;
                2:       rec.plain = row.b0;
                3:       rec.plain = row.len_b;
                default: rec.plain = row.fill;
              endcase
              rec.plain  = rec.plain ^ row.mask;
              rec.pos    = pdx_pkg::INDEX_W'(i);
              rec.last   = (i == PKT - 1);
              rec.mask   = row.mask;
              rec.agrees = (row.mask == row.fill);
              expected_plain = {expected_plain, rec};
            end
          end
        end
      endcase
    end
    pause_until_drained();

    // random frames, mostly full size
    base_bytes   = frame_bytes;
    base_packets = full_packets;
    while (frame_bytes - base_bytes < RAND_BYTES || full_packets - base_packets < RAND_PACKETS)
    begin
      tx_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 1) begin
        send_byte(pdx_pkg::SYNC_LEAD, 1'b1);
        send_byte(byte_t'($urandom_range(0, 255)), 1'b1);
      end else if (pick == 2) begin
        len_b = ($urandom_range(0, 7) == 0) ? byte_t'($urandom_range(0, 255))
                                            : byte_t'($urandom_range(0, 70));
        fill_body(body, len_b, '0, 1'b1);
        send_frame(byte_t'($urandom_range(0, 255)), len_b, body, 1'b1);
      end else begin
        id_b = ($urandom_range(0, 4) != 0) ? pdx_pkg::HDR_WORD[23:16]
                                           : byte_t'($urandom_range(0, 255));
        len_b = pdx_pkg::HDR_WORD[31:24];
        fill_body(body, len_b, '0, 1'b1);
        // about half the packets carry the mask in byte 51
        if ($urandom_range(0, 1) == 0) begin
          m = (id_b == pdx_pkg::HDR_WORD[23:16])
              ? scramble_mask(body[pdx_pkg::IDX_MASK_A - 4], body[pdx_pkg::IDX_MASK_C - 4])
              : '0;
          body[pdx_pkg::IDX_AGREE - 4] = m;
        end
        send_frame(id_b, len_b, body, 1'b1);
      end
      if ($urandom_range(0, 7) == 0) pause_until_drained();
    end

    // wind down
    @(negedge clk);
    in_chan.valid <= 1'b0;
    wait (expected_plain.size() == 0);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("run covered %0d input transfers, %0d full packets, %0d result transfers",
             in_transfers, full_packets, results_seen);
    $display("%0d packets had a mask matching byte 51, one %0d-cycle output stall",
             agree_packets, LONG_HOLD);
    if (errors == 0) begin
      $display("packet_deframe_xor_descramble verification clean");
    end else begin
      $display("packet_deframe_xor_descramble verification failed");
    end
    $finish;
  end

endmodule
